### design/assert_macros.svh
// Assertion helpers shared by the checker modules of this project.
// Each macro takes a label, the clock, the reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### design/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// Types and constants shared by the dirty rectangle tracker modules.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int MAX_ENTRIES   = 8;
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  // Coordinate widths hold 0 up to and including the screen size.
  localparam int X_W   = $clog2(SCREEN_WIDTH + 1);
  localparam int Y_W   = $clog2(SCREEN_HEIGHT + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Request opcodes.
  localparam logic FUNC_INVALIDATE = 1'b0;
  localparam logic FUNC_REFRESH    = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
  } req_t;

  typedef struct packed {
    logic [X_W-1:0] out_x;
    logic [Y_W-1:0] out_y;
    logic [X_W-1:0] out_w;
    logic [Y_W-1:0] out_h;
    logic           last;
  } rsp_t;

  // Stored rectangle as edges; x1 and y1 are exclusive.
  typedef struct packed {
    logic [X_W-1:0] x0;
    logic [X_W-1:0] x1;
    logic [Y_W-1:0] y0;
    logic [Y_W-1:0] y1;
  } rect_t;

  localparam rect_t FULL_SCREEN = '{
    x0: '0, x1: X_W'(SCREEN_WIDTH), y0: '0, y1: Y_W'(SCREEN_HEIGHT)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIP,
    ST_SCAN,
    ST_FULL,
    ST_EMIT
  } state_t;

endpackage

### design/drt_clip.sv
// ----------------------------------------------------------------------------
// drt_clip
// Clips a signed request rectangle to the screen and flags an empty result.
// ----------------------------------------------------------------------------
module drt_clip
  import drt_pkg::*;
(
  input  req_t  cmd,
  output rect_t rect,
  output logic  empty
);

  localparam logic signed [16:0] X_LIM = 17'(SCREEN_WIDTH);
  localparam logic signed [16:0] Y_LIM = 17'(SCREEN_HEIGHT);

  logic signed [16:0] sum_x, sum_y;
  logic signed [16:0] left, right, top, bottom;

  // Far edges at full precision so nothing wraps.
  always_comb begin
    sum_x  = $signed({cmd.rect_x[15], cmd.rect_x}) + $signed({cmd.rect_w[15], cmd.rect_w});
    sum_y  = $signed({cmd.rect_y[15], cmd.rect_y}) + $signed({cmd.rect_h[15], cmd.rect_h});
    left   = cmd.rect_x[15] ? 17'sd0 : $signed({1'b0, cmd.rect_x});
    top    = cmd.rect_y[15] ? 17'sd0 : $signed({1'b0, cmd.rect_y});
    right  = (sum_x > X_LIM) ? X_LIM : sum_x;
    bottom = (sum_y > Y_LIM) ? Y_LIM : sum_y;
    empty  = (right <= left) || (bottom <= top);
  end

  // When not empty every edge lies within the screen and fits the narrow fields.
  assign rect.x0 = left[X_W-1:0];
  assign rect.x1 = right[X_W-1:0];
  assign rect.y0 = top[Y_W-1:0];
  assign rect.y1 = bottom[Y_W-1:0];

endmodule

### design/drt_merge.sv
// ----------------------------------------------------------------------------
// drt_merge
// Shared compare unit: strict overlap test and bounding-box union of two rects.
// ----------------------------------------------------------------------------
module drt_merge
  import drt_pkg::*;
(
  input  rect_t a,
  input  rect_t b,
  output logic  overlap,
  output rect_t joined
);

  // Rectangles that only share an edge do not overlap.
  assign overlap = (a.x0 < b.x1) && (b.x0 < a.x1) && (a.y0 < b.y1) && (b.y0 < a.y1);

  // Bounding box of both.
  assign joined.x0 = (a.x0 < b.x0) ? a.x0 : b.x0;
  assign joined.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
  assign joined.y0 = (a.y0 < b.y0) ? a.y0 : b.y0;
  assign joined.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;

endmodule

### design/dirty_rect_tracker.sv
// ----------------------------------------------------------------------------
// dirty_rect_tracker
// Bounded list of dirty screen rectangles with merge on overlap.
// ----------------------------------------------------------------------------
// An invalidate request is clipped in the clip state; an empty result ends it,
// else the stored entries are compared one per cycle against it through a
// single overlap/union unit; the first strict overlap merges and ends the
// request, otherwise the rectangle is appended, or merged into entry zero
// when all MAX_ENTRIES slots are in use. A refresh reads one entry per cycle
// into the output register while the sink keeps up; a refresh of an empty
// list returns nothing and leaves the block ready. Requests are taken only
// while no request is in work, but a finished result may still wait in the
// output register. After reset the list holds one full-screen entry.
module dirty_rect_tracker
  import drt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t             state, state_next;
  logic   [CNT_W-1:0] idx;
  logic   [CNT_W-1:0] count;
  req_t               cmd;
  rect_t              cand;
  rect_t              store [MAX_ENTRIES];

  logic               req_take;
  logic   [IDX_W-1:0] rd_idx;
  rect_t              entry;
  rect_t              clip_rect;
  logic               clip_empty;
  logic               overlap;
  rect_t              joined;
  logic               at_end;
  logic               list_full;
  logic               emit_go;
  logic               emit_last;

  logic               wr_en;
  logic   [IDX_W-1:0] wr_idx;
  rect_t              wr_data;
  logic               idx_clr;
  logic               idx_inc;
  logic               count_inc;
  logic               count_clr;

  assign req_take  = req_valid && req_ready;
  assign at_end    = (idx == count);
  assign list_full = (count == CNT_W'(MAX_ENTRIES));
  assign emit_last = (idx == count - CNT_W'(1));
  assign emit_go   = (state == ST_EMIT) && (!rsp_valid || rsp_ready);

  // Entry zero is read for the final merge of a full list.
  assign rd_idx = (state == ST_FULL) ? '0 : idx[IDX_W-1:0];
  assign entry  = store[rd_idx];

  drt_clip u_clip (
    .cmd   (cmd),
    .rect  (clip_rect),
    .empty (clip_empty)
  );

  drt_merge u_merge (
    .a       (entry),
    .b       (cand),
    .overlap (overlap),
    .joined  (joined)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          if (req.func == FUNC_REFRESH) begin
            state_next = (count != '0) ? ST_EMIT : ST_IDLE;
          end else begin
            state_next = ST_CLIP;
          end
        end
      end
      ST_CLIP: begin
        state_next = clip_empty ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (at_end) begin
          state_next = list_full ? ST_FULL : ST_IDLE;
        end else if (overlap) begin
          state_next = ST_IDLE;
        end
      end
      ST_FULL: begin
        state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_go && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req_ready = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = idx[IDX_W-1:0];
    wr_data   = cand;
    idx_clr   = 1'b0;
    idx_inc   = 1'b0;
    count_inc = 1'b0;
    count_clr = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        idx_clr   = 1'b1;
      end
      ST_CLIP: begin
        idx_clr = 1'b1;
      end
      ST_SCAN: begin
        if (at_end) begin
          if (!list_full) begin
            wr_en     = 1'b1;
            count_inc = 1'b1;
          end
        end else if (overlap) begin
          wr_en   = 1'b1;
          wr_data = joined;
        end else begin
          idx_inc = 1'b1;
        end
      end
      ST_FULL: begin
        wr_en   = 1'b1;
        wr_idx  = '0;
        wr_data = joined;
      end
      ST_EMIT: begin
        idx_inc   = emit_go;
        count_clr = emit_go && emit_last;
      end
      default: begin
        idx_clr = 1'b1;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      count     <= CNT_W'(1);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (idx_clr) begin
        idx <= '0;
      end else if (idx_inc) begin
        idx <= idx + CNT_W'(1);
      end
      if (count_clr) begin
        count <= '0;
      end else if (count_inc) begin
        count <= count + CNT_W'(1);
      end
      if (emit_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Entry store; only entry zero has a reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      store[0] <= FULL_SCREEN;
    end else if (wr_en) begin
      store[wr_idx] <= wr_data;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_take) begin
      cmd <= req;
    end
    if (state == ST_CLIP) begin
      cand <= clip_rect;
    end
    if (emit_go) begin
      rsp.out_x <= entry.x0;
      rsp.out_y <= entry.y0;
      rsp.out_w <= entry.x1 - entry.x0;
      rsp.out_h <= entry.y1 - entry.y0;
      rsp.last  <= emit_last;
    end
  end

endmodule

### design/drt_checker.sv
// ----------------------------------------------------------------------------
// drt_checker
// Port-level checks for the dirty rectangle tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drt_checker
  import drt_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  localparam logic [X_W:0] X_LIM = (X_W + 1)'(SCREEN_WIDTH);
  localparam logic [Y_W:0] Y_LIM = (Y_W + 1)'(SCREEN_HEIGHT);

  logic [X_W:0] x_end;
  logic [Y_W:0] y_end;
  logic         on_screen;

  assign x_end = {1'b0, rsp.out_x} + {1'b0, rsp.out_w};
  assign y_end = {1'b0, rsp.out_y} + {1'b0, rsp.out_h};
  assign on_screen = (rsp.out_w != '0) && (rsp.out_h != '0) &&
                     (x_end <= X_LIM) && (y_end <= Y_LIM);

  // A result waits until it is taken.
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  // Every emitted rectangle is nonempty and lies on the screen.
  `ASSERT_SAME(a_rsp_on_screen, clk, rst, rsp_valid, on_screen)

  // An invalidate keeps the block busy at least through the clipping state.
  `ASSERT_NEXT(a_inval_busy, clk, rst, req_valid && req_ready && (req.func == FUNC_INVALIDATE), !req_ready)

  // A refresh run streams on without a gap after each transfer but the last.
  `ASSERT_NEXT(a_run_continues, clk, rst, rsp_valid && rsp_ready && !rsp.last, rsp_valid)

endmodule

bind dirty_rect_tracker drt_checker u_drt_checker (.*);

### tb/tb_dirty_rect_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dirty_rect_tracker
// Self-checking bench for the dirty rectangle tracker.
// ----------------------------------------------------------------------------
// A short directed script covers clipping at the numeric extremes, empty and
// touching rectangles, merging, a full list and refreshes of full and empty
// lists. A long random run follows. Every accepted request goes through a
// behavioral model of the list, and each emitted rectangle is compared field
// by field with the oldest predicted one. Both handshakes idle in random
// bursts. The sink also holds off once for a long stretch, and the source
// drains once before it goes on.
module tb_dirty_rect_tracker;
  import drt_pkg::*;

  localparam int RANDOM_ITEMS   = 86;
  localparam int LONG_STALL     = 150;
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  // Model copy of one stored rectangle, at the block's widths.
  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [X_W-1:0] w;
    logic [Y_W-1:0] h;
  } dirty_box_t;

  // One row of the directed script. A typed count of -1 means the model
  // supplies the expected rectangles.
  typedef struct {
    req_t item;
    int   typed_n;
    rsp_t typed_rect;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b1;
  rsp_t rsp;

  // Model state and the rectangles still to come out.
  dirty_box_t       dirty_list [MAX_ENTRIES];
  logic [CNT_W-1:0] dirty_count;
  rsp_t             pending_rects [$];

  int   fault_count = 0;
  rsp_t want;
  bit   long_stall_go = 1'b0;
  bit   calm = 1'b0;
  bit   sender_steady = 1'b0;
  int   sender_phase = 0;

  dirty_rect_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Clock generation.
  initial begin
    forever #10 clk = ~clk;
  end

  function automatic req_t make_req(logic f, int x, int y, int w, int h);
    req_t r;
    r.func   = f;
    r.rect_x = x[15:0];
    r.rect_y = y[15:0];
    r.rect_w = w[15:0];
    r.rect_h = h[15:0];
    return r;
  endfunction

  function automatic rsp_t make_rect(int x, int y, int w, int h, bit is_last);
    rsp_t r;
    r.out_x = X_W'(x);
    r.out_y = Y_W'(y);
    r.out_w = X_W'(w);
    r.out_h = Y_W'(h);
    r.last  = is_last;
    return r;
  endfunction

  function automatic dirty_box_t bound_union(dirty_box_t a, int bx, int by, int bw, int bh);
    dirty_box_t u;
    int x0, y0, x1, y1;
    x0 = (int'(a.x) < bx) ? int'(a.x) : bx;
    y0 = (int'(a.y) < by) ? int'(a.y) : by;
    x1 = (int'(a.x) + int'(a.w) > bx + bw) ? int'(a.x) + int'(a.w) : bx + bw;
    y1 = (int'(a.y) + int'(a.h) > by + bh) ? int'(a.y) + int'(a.h) : by + bh;
    u.x = X_W'(x0);
    u.y = Y_W'(y0);
    u.w = X_W'(x1 - x0);
    u.h = Y_W'(y1 - y0);
    return u;
  endfunction

  // Applies one accepted request to the model list. A refresh queues the
  // stored rectangles when emit is set. Returns 0 when the request has no
  // effect at all (an empty clip, or a refresh of an empty list).
  function automatic bit apply_request(req_t r, bit emit);
    int left, top, right, bottom, cw, ch;
    dirty_box_t clip;
    if (r.func == FUNC_REFRESH) begin
      for (int i = 0; i < dirty_count; i++) begin
        if (emit)
          pending_rects.push_back(make_rect(dirty_list[i].x, dirty_list[i].y,
                                            dirty_list[i].w, dirty_list[i].h,
                                            i == dirty_count - 1));
      end
      apply_request = (dirty_count != 0);
      dirty_count = '0;
      return apply_request;
    end
    // Clip at full precision so that the far edge never wraps.
    left   = (int'(r.rect_x) > 0) ? int'(r.rect_x) : 0;
    top    = (int'(r.rect_y) > 0) ? int'(r.rect_y) : 0;
    right  = int'(r.rect_x) + int'(r.rect_w);
    bottom = int'(r.rect_y) + int'(r.rect_h);
    if (right > SCREEN_WIDTH) right = SCREEN_WIDTH;
    if (bottom > SCREEN_HEIGHT) bottom = SCREEN_HEIGHT;
    if (right <= left || bottom <= top) return 1'b0;
    cw = right - left;
    ch = bottom - top;
    // Merge into the first entry with a strict overlap; shared edges do not count.
    for (int i = 0; i < dirty_count; i++) begin
      if (int'(dirty_list[i].x) < right &&
          left < int'(dirty_list[i].x) + int'(dirty_list[i].w) &&
          int'(dirty_list[i].y) < bottom &&
          top < int'(dirty_list[i].y) + int'(dirty_list[i].h)) begin
        dirty_list[i] = bound_union(dirty_list[i], left, top, cw, ch);
        return 1'b1;
      end
    end
    if (dirty_count < MAX_ENTRIES) begin
      clip.x = X_W'(left);
      clip.y = Y_W'(top);
      clip.w = X_W'(cw);
      clip.h = Y_W'(ch);
      dirty_list[dirty_count] = clip;
      dirty_count = dirty_count + 1'b1;
    end else begin
      // A full list folds the rectangle into entry zero.
      dirty_list[0] = bound_union(dirty_list[0], left, top, cw, ch);
    end
    return 1'b1;
  endfunction

  // Random request. Rolls below 16 give a refresh, below 30 a rectangle with
  // fully random fields, and the rest a rectangle near the screen.
  function automatic req_t random_request(int roll);
    int x, y, w, h;
    if (roll < 16)
      return make_req(FUNC_REFRESH, $urandom, $urandom, $urandom, $urandom);
    if (roll < 30)
      return make_req(FUNC_INVALIDATE, $urandom, $urandom, $urandom, $urandom);
    x = int'($urandom_range(0, 340)) - 20;
    y = int'($urandom_range(0, 260)) - 20;
    w = (roll < 65) ? $urandom_range(1, 24) : $urandom_range(1, 160);
    h = (roll < 65) ? $urandom_range(1, 20) : $urandom_range(1, 120);
    return make_req(FUNC_INVALIDATE, x, y, w, h);
  endfunction

  // Offer one request and return at the edge where it is transferred.
  task automatic offer_request(req_t r);
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Random idle burst on the request side, skipped in steady stretches.
  task automatic sender_gap();
    if (sender_phase == 0) begin
      sender_phase  = 12;
      sender_steady = ($urandom_range(2) == 0);
    end
    sender_phase--;
    if (!calm && !sender_steady && $urandom_range(3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Sink: random idle bursts, steady stretches and one long hold-off.
  initial begin : sink
    int burst, phase;
    bit steady, stall_taken;
    burst = 0;
    phase = 0;
    steady = 1'b0;
    stall_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (phase == 0) begin
        phase  = 64;
        steady = ($urandom_range(2) == 0);
      end
      phase--;
      if (long_stall_go && !stall_taken) begin
        stall_taken = 1'b1;
        burst = LONG_STALL;
      end else if (burst == 0 && !calm && !steady && $urandom_range(4) == 0) begin
        burst = $urandom_range(1, 9);
      end
      if (burst > 0) begin
        rsp_ready <= 1'b0;
        burst--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Compare each transferred rectangle with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rects.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("%0t: unexpected rect x=%0d y=%0d w=%0d h=%0d last=%0b", $realtime,
                   rsp.out_x, rsp.out_y, rsp.out_w, rsp.out_h, rsp.last);
      end else begin
        want = pending_rects.pop_front();
        if (rsp.out_x !== want.out_x || rsp.out_y !== want.out_y ||
            rsp.out_w !== want.out_w || rsp.out_h !== want.out_h ||
            rsp.last !== want.last) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("%0t: rect mismatch: expected x=%0d y=%0d w=%0d h=%0d last=%0b,",
                     $realtime, want.out_x, want.out_y, want.out_w, want.out_h, want.last,
                     " got x=%0d y=%0d w=%0d h=%0d last=%0b",
                     rsp.out_x, rsp.out_y, rsp.out_w, rsp.out_h, rsp.last);
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("** dirty_rect_tracker: FAILED **");
    $finish;
  end

  // Directed script, random run and end of test.
  initial begin : stimulus
    script_row_t script [$];
    req_t item;
    int   n_sent;

    // Model starts with the full screen marked dirty.
    foreach (dirty_list[i]) dirty_list[i] = '0;
    dirty_list[0].w = X_W'(SCREEN_WIDTH);
    dirty_list[0].h = Y_W'(SCREEN_HEIGHT);
    dirty_count = 1;

    // Refresh after reset, then a refresh of the now empty list.
    script.push_back('{make_req(FUNC_REFRESH, -1, 0, -1, 0), 1,
                       make_rect(0, 0, SCREEN_WIDTH, SCREEN_HEIGHT, 1'b1)});
    script.push_back('{make_req(FUNC_REFRESH, 0, -1, 0, -1), 0, '0});
    // Rectangles that clip to nothing, including far edges past 16 bits.
    script.push_back('{make_req(FUNC_INVALIDATE, -32768, -32768, 32767, 32767), -1, '0});
    script.push_back('{make_req(FUNC_INVALIDATE, 32767, 32767, 32767, 32767), -1, '0});
    script.push_back('{make_req(FUNC_INVALIDATE, 10, 10, 0, 50), -1, '0});
    script.push_back('{make_req(FUNC_INVALIDATE, 10, 10, 50, -32768), -1, '0});
    // Huge rectangle clips to the full screen.
    script.push_back('{make_req(FUNC_INVALIDATE, -100, -100, 32767, 32767), -1, '0});
    script.push_back('{make_req(FUNC_REFRESH, 0, 0, 0, 0), 1,
                       make_rect(0, 0, SCREEN_WIDTH, SCREEN_HEIGHT, 1'b1)});
    // Shared edge appends, strict overlap merges.
    script.push_back('{make_req(FUNC_INVALIDATE, 0, 0, 10, 10), -1, '0});
    script.push_back('{make_req(FUNC_INVALIDATE, 10, 0, 10, 10), -1, '0});
    script.push_back('{make_req(FUNC_INVALIDATE, 5, 5, 10, 10), -1, '0});
    script.push_back('{make_req(FUNC_REFRESH, 0, 0, 0, 0), -1, '0});
    // Fill the list with disjoint rectangles, then overflow into entry zero.
    for (int k = 0; k < MAX_ENTRIES; k++)
      script.push_back('{make_req(FUNC_INVALIDATE, k * 40, 0, 20, 20), -1, '0});
    script.push_back('{make_req(FUNC_INVALIDATE, 0, 200, 10, 10), -1, '0});
    script.push_back('{make_req(FUNC_REFRESH, 0, 0, 0, 0), -1, '0});
    // Bottom-right pixel with a far edge that would wrap in 16 bits.
    script.push_back('{make_req(FUNC_INVALIDATE, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1,
                                32767, 32767), -1, '0});
    script.push_back('{make_req(FUNC_REFRESH, 0, 0, 0, 0), 1,
                       make_rect(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 1, 1, 1'b1)});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      sender_gap();
      offer_request(script[i].item);
      if (script[i].typed_n < 0) begin
        void'(apply_request(script[i].item, 1'b1));
      end else begin
        void'(apply_request(script[i].item, 1'b0));
        if (script[i].typed_n == 1) pending_rects.push_back(script[i].typed_rect);
      end
    end

    n_sent = 0;
    while (n_sent < RANDOM_ITEMS) begin
      // Once, let every pending rectangle come out before going on.
      if (n_sent == 60 && pending_rects.size() != 0) begin
        req_valid <= 1'b0;
        while (pending_rects.size() != 0) @(posedge clk);
      end
      sender_gap();
      if (n_sent >= 22 && n_sent <= 24) item = random_request(50);
      else if (n_sent == 25 || n_sent == 26 || n_sent == 59) item = random_request(0);
      else if (n_sent == 58) item = make_req(FUNC_INVALIDATE, 0, 0, 8, 8);
      else item = random_request($urandom_range(99));
      // The sink holds off while refreshes back up behind it.
      if (n_sent == 25) long_stall_go <= 1'b1;
      offer_request(item);
      void'(apply_request(item, 1'b1));
      n_sent++;
      calm <= (n_sent >= RANDOM_ITEMS - 20);
    end
    req_valid <= 1'b0;

    while (pending_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_rects.size() == 0) begin
      $display("** dirty_rect_tracker: PASSED **");
    end else begin
      $display("** dirty_rect_tracker: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/drt_pkg.sv
design/drt_clip.sv
design/drt_merge.sv
design/dirty_rect_tracker.sv
design/drt_checker.sv
tb/tb_dirty_rect_tracker.sv
